FILE: hdl/stable_priority_queue_unit_macros.svh
// assertion macros shared by the priority queue modules
// expects signals named clk and rst in the including module
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold on every clock edge outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define SPQ_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

FILE: hdl/spq_pkg.sv
// shared types and constants for the stable priority queue
// no dependencies
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int OP_W          = 2;
  localparam int PRIO_W        = 16;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int FIELDS_W      = OP_W + PRIO_W + VALUE_W;
  localparam int TDATA_W       = ((FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W         = TDATA_W - FIELDS_W;

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_t;

  // what the output register loads
  typedef enum logic [2:0] {
    OUT_HOLD,
    OUT_OK_ZERO,
    OUT_EMPTY,
    OUT_FULL,
    OUT_HEAD
  } out_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     do_insert;
    logic     do_remove;
    logic     do_rotate;
    out_sel_t out_sel;
    logic     out_last;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
  } stat_t;

endpackage

FILE: hdl/spq_datapath.sv
// entry store, sorted insert, head removal and list rotation, output register
// depends on spq_pkg and stable_priority_queue_unit_macros.svh
`include "stable_priority_queue_unit_macros.svh"

module spq_datapath #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  spq_pkg::cmd_t                       cmd,
  input  logic signed [spq_pkg::PRIO_W-1:0]   new_priority,
  input  logic        [spq_pkg::VALUE_W-1:0]  new_value,
  output spq_pkg::stat_t                      stat,
  output logic        [CW-1:0]                count,
  output logic        [spq_pkg::STATUS_W-1:0] status,
  output logic signed [spq_pkg::PRIO_W-1:0]   out_priority,
  output logic        [spq_pkg::VALUE_W-1:0]  out_value,
  output logic                                last
);

  logic signed [spq_pkg::PRIO_W-1:0]  slot_priority [DEPTH];
  logic        [spq_pkg::VALUE_W-1:0] slot_value    [DEPTH];

  // neighbor taps per slot
  logic signed [spq_pkg::PRIO_W-1:0]  up_priority [DEPTH];
  logic        [spq_pkg::VALUE_W-1:0] up_value    [DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0]  dn_priority [DEPTH];
  logic        [spq_pkg::VALUE_W-1:0] dn_value    [DEPTH];
  logic        [DEPTH-1:0]            le;
  logic        [DEPTH-1:0]            prev_le;
  logic        [DEPTH-1:0]            in_range;
  logic        [DEPTH-1:0]            is_tail;
  logic        [CW-1:0]               tail_idx;

  assign tail_idx = count - 1'b1;

  // per-slot compare and neighbor wiring
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    localparam logic [CW-1:0] IDX = CW'(i);

    assign le[i]       = (IDX < count) && (slot_priority[i] <= new_priority);
    assign in_range[i] = (IDX < tail_idx);
    assign is_tail[i]  = (IDX == tail_idx);

    if (i == 0) begin : g_head
      assign prev_le[i]     = 1'b1;
      assign dn_priority[i] = new_priority;
      assign dn_value[i]    = new_value;
    end else begin : g_body
      assign prev_le[i]     = le[i-1];
      assign dn_priority[i] = slot_priority[i-1];
      assign dn_value[i]    = slot_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign up_priority[i] = slot_priority[i];
      assign up_value[i]    = slot_value[i];
    end else begin : g_mid
      assign up_priority[i] = slot_priority[i+1];
      assign up_value[i]    = slot_value[i+1];
    end
  end

  // slot updates: shift down on insert, shift up on remove, rotate on list
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.do_insert) begin
        if (!le[i]) begin
          if (prev_le[i]) begin
            slot_priority[i] <= new_priority;
            slot_value[i]    <= new_value;
          end else begin
            slot_priority[i] <= dn_priority[i];
            slot_value[i]    <= dn_value[i];
          end
        end
      end else if (cmd.do_remove) begin
        slot_priority[i] <= up_priority[i];
        slot_value[i]    <= up_value[i];
      end else if (cmd.do_rotate) begin
        if (is_tail[i]) begin
          slot_priority[i] <= slot_priority[0];
          slot_value[i]    <= slot_value[0];
        end else if (in_range[i]) begin
          slot_priority[i] <= up_priority[i];
          slot_value[i]    <= up_value[i];
        end
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.do_insert) begin
      count <= count + 1'b1;
    end else if (cmd.do_remove) begin
      count <= count - 1'b1;
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count >= CW'(DEPTH));

  // output register
  always_ff @(posedge clk) begin
    unique case (cmd.out_sel)
      spq_pkg::OUT_HOLD: begin
      end
      spq_pkg::OUT_OK_ZERO: begin
        status       <= spq_pkg::STATUS_OK;
        out_priority <= '0;
        out_value    <= '0;
        last         <= cmd.out_last;
      end
      spq_pkg::OUT_EMPTY: begin
        status       <= spq_pkg::STATUS_EMPTY;
        out_priority <= '0;
        out_value    <= '0;
        last         <= cmd.out_last;
      end
      spq_pkg::OUT_FULL: begin
        status       <= spq_pkg::STATUS_FULL;
        out_priority <= '0;
        out_value    <= '0;
        last         <= cmd.out_last;
      end
      spq_pkg::OUT_HEAD: begin
        status       <= spq_pkg::STATUS_OK;
        out_priority <= slot_priority[0];
        out_value    <= slot_value[0];
        last         <= cmd.out_last;
      end
      default: begin
      end
    endcase
  end

  // checks
  `SPQ_ASSERT_NEVER(a_count_range, count > CW'(DEPTH), "entry count above depth")
  `SPQ_ASSERT(a_insert_grows, cmd.do_insert |=> count == $past(count) + 1'b1, "insert count")
  `SPQ_ASSERT(a_remove_shrinks, cmd.do_remove |=> count == $past(count) - 1'b1, "remove count")
  `SPQ_ASSERT_NEVER(a_insert_full, cmd.do_insert && stat.full, "insert into full store")

endmodule

FILE: hdl/spq_ctrl.sv
// request controller: handshake, op decode, list sequencing
// depends on spq_pkg and stable_priority_queue_unit_macros.svh
`include "stable_priority_queue_unit_macros.svh"

module spq_ctrl #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  spq_pkg::op_t   operation,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  spq_pkg::stat_t stat,
  input  logic [CW-1:0]  count,
  output spq_pkg::cmd_t  cmd
);

  spq_pkg::state_t state;
  spq_pkg::state_t state_next;
  logic [CW-1:0]   remain;
  logic [CW-1:0]   remain_next;
  logic            busy;
  logic            finish;
  logic            advance;
  logic            take;

  // handshake
  assign busy     = (state == spq_pkg::ST_BUSY);
  assign finish   = busy && m_tready && (remain == '0);
  assign advance  = busy && m_tready && (remain != '0);
  assign s_tready = !busy || finish;
  assign take     = s_tvalid && s_tready;
  assign m_tvalid = busy;

  // next state and remaining list beats
  always_comb begin
    state_next  = state;
    remain_next = remain;
    if (take) begin
      unique case (operation)
        spq_pkg::OP_INSERT, spq_pkg::OP_REMOVE: begin
          state_next  = spq_pkg::ST_BUSY;
          remain_next = '0;
        end
        spq_pkg::OP_LIST: begin
          state_next  = spq_pkg::ST_BUSY;
          remain_next = stat.empty ? '0 : count - 1'b1;
        end
        spq_pkg::OP_NONE: begin
          state_next  = spq_pkg::ST_IDLE;
          remain_next = '0;
        end
        default: begin
          state_next  = spq_pkg::ST_IDLE;
          remain_next = '0;
        end
      endcase
    end else if (finish) begin
      state_next = spq_pkg::ST_IDLE;
    end else if (advance) begin
      remain_next = remain - 1'b1;
    end
  end

  // datapath commands
  always_comb begin
    cmd = '{do_insert: 1'b0, do_remove: 1'b0, do_rotate: 1'b0,
            out_sel: spq_pkg::OUT_HOLD, out_last: 1'b1};
    if (take) begin
      unique case (operation)
        spq_pkg::OP_INSERT: begin
          if (stat.full) begin
            cmd.out_sel = spq_pkg::OUT_FULL;
          end else begin
            cmd.do_insert = 1'b1;
            cmd.out_sel   = spq_pkg::OUT_OK_ZERO;
          end
        end
        spq_pkg::OP_REMOVE: begin
          if (stat.empty) begin
            cmd.out_sel = spq_pkg::OUT_EMPTY;
          end else begin
            cmd.do_remove = 1'b1;
            cmd.out_sel   = spq_pkg::OUT_HEAD;
          end
        end
        spq_pkg::OP_LIST: begin
          if (stat.empty) begin
            cmd.out_sel = spq_pkg::OUT_EMPTY;
          end else begin
            cmd.do_rotate = 1'b1;
            cmd.out_sel   = spq_pkg::OUT_HEAD;
            cmd.out_last  = (count == CW'(1));
          end
        end
        spq_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end else if (advance) begin
      cmd.do_rotate = 1'b1;
      cmd.out_sel   = spq_pkg::OUT_HEAD;
      cmd.out_last  = (remain == CW'(1));
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= spq_pkg::ST_IDLE;
      remain <= '0;
    end else begin
      state  <= state_next;
      remain <= remain_next;
    end
  end

  // checks
  `SPQ_ASSERT_NEVER(a_idle_remain, !busy && (remain != '0), "idle with list beats left")
  `SPQ_ASSERT_NEVER(a_remain_count, busy && (remain != '0) && (remain >= count), "list overrun")
  `SPQ_ASSERT(a_list_count, advance |=> $stable(count), "store changed during list")

endmodule

FILE: hdl/stable_priority_queue_unit.sv
// stable priority queue top: stream ports, controller and datapath
// insert/remove: result valid the cycle after the request, one request per cycle
// when results are taken at once; list of n entries: n results on consecutive
// cycles if taken at once, each set by one store rotation; next request taken
// with the last beat. reset clears the entry count and controller state only.
// depends on spq_pkg, spq_ctrl, spq_datapath

module stable_priority_queue_unit #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // operation[1:0], new_priority[17:2], new_value[49:18], zero pad
  input  logic [spq_pkg::TDATA_W-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // status[1:0], out_priority[17:2], out_value[49:18], zero pad
  output logic [spq_pkg::TDATA_W-1:0]  m_tdata,
  output logic                         m_tlast
);

  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::cmd_t                       cmd;
  spq_pkg::stat_t                      stat;
  spq_pkg::op_t                        operation;
  logic        [CW-1:0]                count;
  logic signed [spq_pkg::PRIO_W-1:0]   new_priority;
  logic        [spq_pkg::VALUE_W-1:0]  new_value;
  logic        [spq_pkg::STATUS_W-1:0] status;
  logic signed [spq_pkg::PRIO_W-1:0]   out_priority;
  logic        [spq_pkg::VALUE_W-1:0]  out_value;

  // request field unpacking
  assign operation    = spq_pkg::op_t'(s_tdata[spq_pkg::OP_W-1:0]);
  assign new_priority = s_tdata[spq_pkg::OP_W +: spq_pkg::PRIO_W];
  assign new_value    = s_tdata[spq_pkg::OP_W + spq_pkg::PRIO_W +: spq_pkg::VALUE_W];

  // result packing
  assign m_tdata = {{spq_pkg::PAD_W{1'b0}}, out_value, out_priority, status};

  spq_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .operation (operation),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .stat      (stat),
    .count     (count),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .new_priority (new_priority),
    .new_value    (new_value),
    .stat         (stat),
    .count        (count),
    .status       (status),
    .out_priority (out_priority),
    .out_value    (out_value),
    .last         (m_tlast)
  );

endmodule
